// File: hw/rtl/lif_pkg.sv
// Shared types and constants for the leaky integrate-and-fire neuron.
`default_nettype none

package lif_pkg;

    // fixed widths of the channel fields and the register port
    localparam int FIELD_W   = 16;
    localparam int CFG_IDX_W = 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LEAK_RATE         = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRE_THRESHOLD    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REFRACTORY_PERIOD = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP         = 8'd3;

    // register reset values, Q4.12
    localparam logic [FIELD_W-1:0] RST_LEAK_RATE         = 16'd205;   // ~0.05
    localparam logic [FIELD_W-1:0] RST_FIRE_THRESHOLD    = 16'd2048;  // 0.5
    localparam logic [FIELD_W-1:0] RST_REFRACTORY_PERIOD = 16'd8192;  // 2.0
    localparam logic [FIELD_W-1:0] RST_TIME_STEP         = 16'd819;   // ~0.2

    // item modes
    localparam logic MODE_TICK     = 1'b0;
    localparam logic MODE_STIMULUS = 1'b1;

    typedef struct packed {
        logic [FIELD_W-1:0] leak_rate;
        logic [FIELD_W-1:0] fire_threshold;
        logic [FIELD_W-1:0] refractory_period;
        logic [FIELD_W-1:0] time_step;
    } t_cfg;

    typedef struct packed {
        logic               mode;
        logic [FIELD_W-1:0] weight;
    } t_item;

    typedef struct packed {
        logic               fired;
        logic [FIELD_W-1:0] excitation_now;
        logic [FIELD_W-1:0] refractory_left;
    } t_result;

endpackage

`default_nettype wire

// File: hw/rtl/lif_if.sv
// Channel interfaces: input items, result items and register writes.
`default_nettype none

interface lif_in_if;
    logic                        valid;
    logic                        ready;
    logic                        mode;
    logic [lif_pkg::FIELD_W-1:0] weight;

    modport source (output valid, mode, weight, input ready);
    modport sink   (input valid, mode, weight, output ready);
endinterface

interface lif_res_if;
    logic                        valid;
    logic                        ready;
    logic                        fired;
    logic [lif_pkg::FIELD_W-1:0] excitation_now;
    logic [lif_pkg::FIELD_W-1:0] refractory_left;

    modport source (output valid, fired, excitation_now, refractory_left, input ready);
    modport sink   (input valid, fired, excitation_now, refractory_left, output ready);
endinterface

interface lif_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [lif_pkg::CFG_IDX_W-1:0] index;
    logic [lif_pkg::FIELD_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/lif_cfg_regs.sv
// Register file for the neuron's four configuration registers.
`default_nettype none

module lif_cfg_regs (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    lif_cfg_if.sink        i_cfg,
    output lif_pkg::t_cfg  o_cfg
);

    lif_pkg::t_cfg r_cfg;
    logic          w_wr;

    // writes are always taken; unknown indexes are dropped
    assign i_cfg.ready = 1'b1;
    assign w_wr        = i_cfg.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.leak_rate         <= lif_pkg::RST_LEAK_RATE;
            r_cfg.fire_threshold    <= lif_pkg::RST_FIRE_THRESHOLD;
            r_cfg.refractory_period <= lif_pkg::RST_REFRACTORY_PERIOD;
            r_cfg.time_step         <= lif_pkg::RST_TIME_STEP;
        end else if (w_wr) begin
            case (i_cfg.index)
                lif_pkg::REG_LEAK_RATE:         r_cfg.leak_rate         <= i_cfg.data;
                lif_pkg::REG_FIRE_THRESHOLD:    r_cfg.fire_threshold    <= i_cfg.data;
                lif_pkg::REG_REFRACTORY_PERIOD: r_cfg.refractory_period <= i_cfg.data;
                lif_pkg::REG_TIME_STEP:         r_cfg.time_step         <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: hw/rtl/lif_core.sv
// Neuron state and the single-pass update for one stimulus or tick.
`default_nettype none

module lif_core #(
    parameter int FRAC_BITS   = 12,
    parameter int VALUE_WIDTH = 16
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_step,
    input  wire lif_pkg::t_item i_item,
    input  wire lif_pkg::t_cfg  i_cfg,
    output lif_pkg::t_result    o_result
);

    localparam int VW = VALUE_WIDTH;
    localparam int WW = (VW > lif_pkg::FIELD_W) ? VW : lif_pkg::FIELD_W;
    localparam int PW = 2 * VW;
    localparam int DW = PW - FRAC_BITS;
    localparam int CW = (VW > DW) ? VW : DW;

    logic [VW-1:0] r_exc, n_exc;
    logic [VW-1:0] r_refr, n_refr;
    logic [DW-1:0] r_leak_drain;

    // register fields brought to the value width (extend or truncate)
    logic [WW-1:0] w_leak_w, w_step_w, w_period_w, w_thr_w, w_weight_w, w_exc_w;
    logic [VW-1:0] w_leak_v, w_step_v, w_period_v;

    assign w_leak_w   = WW'(i_cfg.leak_rate);
    assign w_step_w   = WW'(i_cfg.time_step);
    assign w_period_w = WW'(i_cfg.refractory_period);
    assign w_thr_w    = WW'(i_cfg.fire_threshold);
    assign w_weight_w = WW'(i_item.weight);
    assign w_exc_w    = WW'(r_exc);
    assign w_leak_v   = w_leak_w[VW-1:0];
    assign w_step_v   = w_step_w[VW-1:0];
    assign w_period_v = w_period_w[VW-1:0];

    // leak per tick depends on registers only; registered ahead of use
    logic [PW-1:0] w_leak_prod;
    assign w_leak_prod = PW'(w_leak_v) * PW'(w_step_v);

    always_ff @(posedge i_clk) begin
        r_leak_drain <= w_leak_prod[PW-1:FRAC_BITS];
    end

    // stimulus: saturating add
    logic [WW:0]   w_sum;
    logic [VW-1:0] w_stim_exc;
    assign w_sum      = {1'b0, w_exc_w} + {1'b0, w_weight_w};
    assign w_stim_exc = (|w_sum[WW:VW]) ? '1 : w_sum[VW-1:0];

    // tick: refractory drain, leak, fire decision
    logic [PW-1:0] w_refr_prod;
    logic [CW-1:0] w_exc_c, w_rdrain_c, w_exc1_c, w_ldrain_c, w_exc2_c;
    logic [VW-1:0] w_refr1;
    logic          w_fire;

    always_comb begin
        w_refr_prod = PW'(r_refr) * PW'(w_step_v);
        w_exc_c     = CW'(r_exc);
        w_rdrain_c  = CW'(w_refr_prod[PW-1:FRAC_BITS]);
        w_ldrain_c  = CW'(r_leak_drain);

        // drain only while refractory time remains
        if (r_refr != '0) begin
            w_exc1_c = (w_exc_c > w_rdrain_c) ? (w_exc_c - w_rdrain_c) : '0;
        end else begin
            w_exc1_c = w_exc_c;
        end
        w_exc2_c = (w_exc1_c > w_ldrain_c) ? (w_exc1_c - w_ldrain_c) : '0;

        w_refr1 = (r_refr > w_step_v) ? (r_refr - w_step_v) : '0;
        w_fire  = (w_exc_w > w_thr_w) && (w_refr1 == '0);
    end

    // next state by mode
    always_comb begin
        case (i_item.mode)
            lif_pkg::MODE_STIMULUS: begin
                n_exc  = w_stim_exc;
                n_refr = r_refr;
            end
            default: begin
                n_exc  = w_fire ? '0 : w_exc2_c[VW-1:0];
                n_refr = w_fire ? w_period_v : w_refr1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exc  <= '0;
            r_refr <= '0;
        end else if (i_step) begin
            r_exc  <= n_exc;
            r_refr <= n_refr;
        end
    end

    // result fields, cut to the channel width
    logic [WW-1:0] w_exc_out, w_refr_out;
    assign w_exc_out  = WW'(n_exc);
    assign w_refr_out = WW'(n_refr);

    assign o_result.fired           = (i_item.mode == lif_pkg::MODE_TICK) && w_fire;
    assign o_result.excitation_now  = w_exc_out[lif_pkg::FIELD_W-1:0];
    assign o_result.refractory_left = w_refr_out[lif_pkg::FIELD_W-1:0];

endmodule

`default_nettype wire

// File: hw/rtl/leaky_integrate_fire_neuron.sv
// Top level of the leaky integrate-and-fire neuron.
//
//   channel  | modport       | beat carries
//   ---------+---------------+-------------------------------------------
//   i_in     | lif_in  sink  | mode, weight
//   o_res    | lif_res source| fired, excitation_now, refractory_left
//   i_cfg    | lif_cfg sink  | index, data (register write, always ready)
//
// One result per input beat, one beat per cycle sustained while results are
// taken; the result is registered (input register, then the state update
// with one multiply feeding the result register).
// Reset is synchronous and clears both stages and the neuron state.
// A stalled result holds; one more input beat waits in the input register.
`default_nettype none

module leaky_integrate_fire_neuron #(
    parameter int FRAC_BITS   = 12,
    parameter int VALUE_WIDTH = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    lif_in_if.sink     i_in,
    lif_res_if.source  o_res,
    lif_cfg_if.sink    i_cfg
);

    lif_pkg::t_cfg    w_cfg;
    lif_pkg::t_item   r_item;
    lif_pkg::t_result w_result, r_result;
    logic             r_in_valid, r_out_valid;
    logic             w_adv, w_in_acc;

    lif_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    // stage handshake
    assign w_adv      = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_in.ready = !r_in_valid || w_adv;
    assign w_in_acc   = i_in.valid && i_in.ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_item.mode   <= i_in.mode;
            r_item.weight <= i_in.weight;
        end
    end

    lif_core #(
        .FRAC_BITS   (FRAC_BITS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_adv),
        .i_item   (r_item),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_result <= w_result;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.fired           = r_result.fired;
    assign o_res.excitation_now  = r_result.excitation_now;
    assign o_res.refractory_left = r_result.refractory_left;

endmodule

`default_nettype wire

// File: hw/rtl/lif_checker.sv
// Port-level checks for the neuron, bound to the top level.
`default_nettype none

module lif_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_in_valid,
    input wire logic                        i_in_ready,
    input wire logic                        i_out_valid,
    input wire logic                        i_out_ready,
    input wire logic                        i_out_fired,
    input wire logic [lif_pkg::FIELD_W-1:0] i_out_exc,
    input wire logic [lif_pkg::FIELD_W-1:0] i_out_refr
);

    // beats accepted but not yet delivered
    logic [2:0] r_cnt, n_cnt;
    logic       w_in_acc, w_out_acc;

    assign w_in_acc  = i_in_valid && i_in_ready;
    assign w_out_acc = i_out_valid && i_out_ready;

    always_comb begin
        n_cnt = r_cnt + {2'b00, w_in_acc} - {2'b00, w_out_acc};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // a stalled result holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_fired) && $stable(i_out_exc) && $stable(i_out_refr))
        else $error("result changed while stalled");

    // a spike always clears excitation
    a_fire_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_fired |-> i_out_exc == '0)
        else $error("spike with nonzero excitation");

    // only two stages can hold beats
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd2)
        else $error("more beats in flight than stages");

    // no result without an accepted input beat
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 3'd0 |-> !i_out_valid)
        else $error("result with no input beat outstanding");

endmodule

bind leaky_integrate_fire_neuron lif_checker u_lif_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_fired (o_res.fired),
    .i_out_exc   (o_res.excitation_now),
    .i_out_refr  (o_res.refractory_left)
);

`default_nettype wire

// File: tb/sv/tb_leaky_integrate_fire_neuron.sv
// Self-checking testbench for the leaky integrate-and-fire neuron.
`timescale 1ns / 100ps

module tb_leaky_integrate_fire_neuron;

    localparam int Q_FRAC        = 12;
    localparam int Q_WIDTH       = 16;
    localparam int ITEMS_PER_SET = 50;
    localparam int SETS_PER_MODE = 2;
    localparam int HOLD_CYCLES   = 80;
    localparam int QUIET_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int REPORT_MAX    = 10;

    // register indexes past the end of the map, writes must be dropped
    localparam logic [lif_pkg::CFG_IDX_W-1:0] REG_PAST_LAST = lif_pkg::REG_TIME_STEP + 8'd1;
    localparam logic [lif_pkg::CFG_IDX_W-1:0] REG_TOP_INDEX = '1;

    // idle and stall odds per traffic mode, percent of cycles
    localparam int unsigned SEND_IDLE_PCT [4] = '{0, 83, 0, 10};
    localparam int unsigned RECV_STALL_PCT[4] = '{0, 0, 83, 10};

    typedef enum logic {ROW_ITEM, ROW_WRITE} t_row_kind;

    // one row of the directed table: an item beat or a register write
    typedef struct packed {
        t_row_kind                         kind;
        logic [lif_pkg::CFG_IDX_W-1:0]     index;
        logic [lif_pkg::FIELD_W-1:0]       data;
        lif_pkg::t_item                    item;
        logic                              known;
        lif_pkg::t_result                  want;
    } t_dir_row;

    // per-beat note: a hand-typed result overrides the prediction
    typedef struct packed {
        logic             known;
        lif_pkg::t_result want;
    } t_beat_note;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lif_in_if  in_ch ();
    lif_res_if res_ch ();
    lif_cfg_if cfg_ch ();

    leaky_integrate_fire_neuron #(
        .FRAC_BITS  (Q_FRAC),
        .VALUE_WIDTH(Q_WIDTH)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_res  (res_ch),
        .i_cfg  (cfg_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // neuron state and registers as the testbench sees them
    lif_pkg::t_cfg               neuron_cfg;
    logic [lif_pkg::FIELD_W-1:0] excitation_lvl;
    logic [lif_pkg::FIELD_W-1:0] refractory_lvl;

    lif_pkg::t_result spike_q[$];
    t_beat_note       note_q[$];

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    bit          hold_go        = 1'b0;

    int unsigned mismatch_cnt   = 0;
    int unsigned item_cnt       = 0;
    int unsigned tick_cnt       = 0;
    int unsigned spike_cnt      = 0;
    int unsigned write_cnt      = 0;
    int unsigned backpress_cnt  = 0;
    int unsigned quiet_cnt      = 0;

    function automatic logic [lif_pkg::FIELD_W-1:0] sat_minus(
            logic [lif_pkg::FIELD_W-1:0] a, logic [31:0] b);
        return (32'(a) > b) ? a - b[lif_pkg::FIELD_W-1:0] : '0;
    endfunction

    // advance the neuron by one beat and return what it should report
    function automatic lif_pkg::t_result neuron_update(lif_pkg::t_item it);
        logic [31:0]                 drain;
        logic [lif_pkg::FIELD_W:0]   sum;
        logic [lif_pkg::FIELD_W-1:0] net;
        logic [lif_pkg::FIELD_W-1:0] exc;
        lif_pkg::t_result            r;
        r.fired = 1'b0;
        if (it.mode == lif_pkg::MODE_STIMULUS) begin
            sum = {1'b0, excitation_lvl} + {1'b0, it.weight};
            excitation_lvl = sum[lif_pkg::FIELD_W] ? '1 : sum[lif_pkg::FIELD_W-1:0];
        end else begin
            net = excitation_lvl;
            exc = excitation_lvl;
            // refractory drain, then leak, both truncated products
            if (refractory_lvl != '0) begin
                drain = (32'(refractory_lvl) * 32'(neuron_cfg.time_step)) >> Q_FRAC;
                exc = sat_minus(exc, drain);
                refractory_lvl = sat_minus(refractory_lvl, 32'(neuron_cfg.time_step));
            end
            drain = (32'(neuron_cfg.leak_rate) * 32'(neuron_cfg.time_step)) >> Q_FRAC;
            exc = sat_minus(exc, drain);
            if (net > neuron_cfg.fire_threshold && refractory_lvl == '0) begin
                r.fired = 1'b1;
                exc = '0;
                refractory_lvl = neuron_cfg.refractory_period;
            end
            excitation_lvl = exc;
        end
        r.excitation_now  = excitation_lvl;
        r.refractory_left = refractory_lvl;
        return r;
    endfunction

    function automatic void apply_write(logic [lif_pkg::CFG_IDX_W-1:0] idx,
                                        logic [lif_pkg::FIELD_W-1:0] data);
        case (idx)
            lif_pkg::REG_LEAK_RATE:         neuron_cfg.leak_rate         = data;
            lif_pkg::REG_FIRE_THRESHOLD:    neuron_cfg.fire_threshold    = data;
            lif_pkg::REG_REFRACTORY_PERIOD: neuron_cfg.refractory_period = data;
            lif_pkg::REG_TIME_STEP:         neuron_cfg.time_step         = data;
            default: ;
        endcase
    endfunction

    task automatic flag_field(string what, logic [lif_pkg::FIELD_W-1:0] want,
                              logic [lif_pkg::FIELD_W-1:0] got);
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_MAX)
            $display("%0t mismatch on %s: expected %h, got %h", $realtime, what, want, got);
    endtask

    // track the register writes and input beats, check each result beat
    always @(posedge i_clk) begin
        lif_pkg::t_result got;
        lif_pkg::t_result want;
        lif_pkg::t_result guess;
        t_beat_note       note;
        if (!i_rst_n) begin
            neuron_cfg     = '{lif_pkg::RST_LEAK_RATE, lif_pkg::RST_FIRE_THRESHOLD,
                               lif_pkg::RST_REFRACTORY_PERIOD, lif_pkg::RST_TIME_STEP};
            excitation_lvl = '0;
            refractory_lvl = '0;
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                apply_write(cfg_ch.index, cfg_ch.data);
                write_cnt++;
            end
            if (in_ch.valid && !in_ch.ready)
                backpress_cnt++;
            if (in_ch.valid && in_ch.ready) begin
                guess = neuron_update('{in_ch.mode, in_ch.weight});
                note  = note_q.pop_front();
                spike_q.push_back(note.known ? note.want : guess);
                item_cnt++;
                if (in_ch.mode == lif_pkg::MODE_TICK)
                    tick_cnt++;
            end
            if (res_ch.valid && res_ch.ready) begin
                got.fired           = res_ch.fired;
                got.excitation_now  = res_ch.excitation_now;
                got.refractory_left = res_ch.refractory_left;
                if (got.fired)
                    spike_cnt++;
                if (spike_q.size() == 0) begin
                    flag_field("unexpected result beat", '0, got.excitation_now);
                end else begin
                    want = spike_q.pop_front();
                    if (got.fired != want.fired)
                        flag_field("fired", lif_pkg::FIELD_W'(want.fired),
                                   lif_pkg::FIELD_W'(got.fired));
                    if (got.excitation_now != want.excitation_now)
                        flag_field("excitation_now", want.excitation_now, got.excitation_now);
                    if (got.refractory_left != want.refractory_left)
                        flag_field("refractory_left", want.refractory_left,
                                   got.refractory_left);
                end
            end
        end
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            quiet_cnt = 0;
        else
            quiet_cnt++;
        if (quiet_cnt >= QUIET_LIMIT) begin
            $display("watchdog: no beat in %0d cycles, %0d results outstanding",
                     QUIET_LIMIT, spike_q.size());
            $display("FAILURE");
            $finish;
        end
    end

    // result side: random stalls plus one long hold-off on request
    initial begin : result_sink
        int unsigned hold_left;
        bit          hold_seen;
        hold_left = 0;
        hold_seen = 1'b0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_go && !hold_seen) begin
                hold_seen = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                res_ch.ready = 1'b0;
            end else begin
                res_ch.ready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // present one item beat; entered and left at a falling edge
    task automatic send_item(lif_pkg::t_item it, logic known, lif_pkg::t_result want);
        t_beat_note note;
        note.known = known;
        note.want  = want;
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        note_q.push_back(note);
        in_ch.valid  = 1'b1;
        in_ch.mode   = it.mode;
        in_ch.weight = it.weight;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    // register write, only once every result has come back
    task automatic cfg_write(logic [lif_pkg::CFG_IDX_W-1:0] idx,
                             logic [lif_pkg::FIELD_W-1:0] data);
        in_ch.valid = 1'b0;
        while (spike_q.size() != 0 || note_q.size() != 0)
            @(negedge i_clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    function automatic lif_pkg::t_result spike(logic fired, logic [lif_pkg::FIELD_W-1:0] exc,
                                               logic [lif_pkg::FIELD_W-1:0] refr);
        return '{fired, exc, refr};
    endfunction

    function automatic t_dir_row item_row(logic mode, logic [lif_pkg::FIELD_W-1:0] weight,
                                          logic known, lif_pkg::t_result want);
        return '{ROW_ITEM, '0, '0, '{mode, weight}, known, want};
    endfunction

    function automatic t_dir_row write_row(logic [lif_pkg::CFG_IDX_W-1:0] idx,
                                           logic [lif_pkg::FIELD_W-1:0] data);
        return '{ROW_WRITE, idx, data, '0, 1'b0, '0};
    endfunction

    function automatic logic [lif_pkg::FIELD_W-1:0] draw_reg(int unsigned hi);
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return '1;
        return lif_pkg::FIELD_W'($urandom_range(hi));
    endfunction

    // random stimuli and ticks, weights mostly up to 16'h1000, with a share of wild weights
    function automatic lif_pkg::t_item draw_item();
        lif_pkg::t_item it;
        it.mode = ($urandom_range(99) < 45) ? lif_pkg::MODE_STIMULUS : lif_pkg::MODE_TICK;
        case ($urandom_range(9))
            8:       it.weight = '1;
            9:       it.weight = '0;
            6, 7:    it.weight = lif_pkg::FIELD_W'($urandom());
            default: it.weight = lif_pkg::FIELD_W'($urandom_range(16'h1000));
        endcase
        return it;
    endfunction

    initial begin : stimulus
        t_dir_row       dir_table[$];
        lif_pkg::t_item it;
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.mode   = lif_pkg::MODE_TICK;
        in_ch.weight = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data  = '0;

        dir_table = '{
            // reset state, tick ignores its weight
            item_row(lif_pkg::MODE_STIMULUS, 16'h0000, 1'b1, spike(1'b0, 16'h0000, 16'h0000)),
            item_row(lif_pkg::MODE_TICK,     16'hFFFF, 1'b1, spike(1'b0, 16'h0000, 16'h0000)),
            // stimulus saturates, then a spike with the default period
            item_row(lif_pkg::MODE_STIMULUS, 16'hFFFF, 1'b1, spike(1'b0, 16'hFFFF, 16'h0000)),
            item_row(lif_pkg::MODE_STIMULUS, 16'h0001, 1'b1, spike(1'b0, 16'hFFFF, 16'h0000)),
            item_row(lif_pkg::MODE_TICK,     16'h0000, 1'b1, spike(1'b1, 16'h0000, 16'h2000)),
            item_row(lif_pkg::MODE_TICK,     16'h0000, 1'b1, spike(1'b0, 16'h0000, 16'h1CCD)),
            // huge step: refractory time stops at zero
            write_row(lif_pkg::REG_TIME_STEP, 16'hFFFF),
            item_row(lif_pkg::MODE_TICK,     16'h0000, 1'b1, spike(1'b0, 16'h0000, 16'h0000)),
            // zero threshold fires on any excitation
            write_row(lif_pkg::REG_LEAK_RATE, 16'h0000),
            write_row(lif_pkg::REG_FIRE_THRESHOLD, 16'h0000),
            item_row(lif_pkg::MODE_STIMULUS, 16'h0001, 1'b1, spike(1'b0, 16'h0001, 16'h0000)),
            item_row(lif_pkg::MODE_TICK,     16'h0000, 1'b1, spike(1'b1, 16'h0000, 16'h2000)),
            // net equal to threshold does not fire; wide drain product clears
            write_row(lif_pkg::REG_REFRACTORY_PERIOD, 16'hFFFF),
            write_row(lif_pkg::REG_FIRE_THRESHOLD, 16'hFFFF),
            item_row(lif_pkg::MODE_STIMULUS, 16'hFFFF, 1'b1, spike(1'b0, 16'hFFFF, 16'h2000)),
            item_row(lif_pkg::MODE_TICK,     16'h0000, 1'b1, spike(1'b0, 16'h0000, 16'h0000)),
            // full leak, unit step, maximum period
            write_row(lif_pkg::REG_LEAK_RATE, 16'hFFFF),
            write_row(lif_pkg::REG_TIME_STEP, 16'h1000),
            write_row(lif_pkg::REG_FIRE_THRESHOLD, 16'h0000),
            item_row(lif_pkg::MODE_STIMULUS, 16'h8000, 1'b1, spike(1'b0, 16'h8000, 16'h0000)),
            item_row(lif_pkg::MODE_TICK,     16'h0000, 1'b1, spike(1'b1, 16'h0000, 16'hFFFF)),
            item_row(lif_pkg::MODE_TICK,     16'h0000, 1'b1, spike(1'b0, 16'h0000, 16'hEFFF)),
            // writes past the register map are dropped
            write_row(REG_PAST_LAST, 16'h0000),
            write_row(REG_TOP_INDEX, 16'h1234),
            // odd step so both products truncate
            write_row(lif_pkg::REG_LEAK_RATE, 16'h0003),
            write_row(lif_pkg::REG_TIME_STEP, 16'h0801),
            write_row(lif_pkg::REG_FIRE_THRESHOLD, 16'h0800),
            item_row(lif_pkg::MODE_STIMULUS, 16'h0A5A, 1'b0, '0),
            item_row(lif_pkg::MODE_TICK,     16'h0000, 1'b0, '0),
            item_row(lif_pkg::MODE_TICK,     16'h0000, 1'b0, '0),
            item_row(lif_pkg::MODE_STIMULUS, 16'h5555, 1'b0, '0),
            item_row(lif_pkg::MODE_STIMULUS, 16'hAAAA, 1'b0, '0),
            item_row(lif_pkg::MODE_TICK,     16'h0000, 1'b0, '0),
            item_row(lif_pkg::MODE_TICK,     16'h0000, 1'b0, '0)
        };

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table, no idling
        foreach (dir_table[k]) begin
            if (dir_table[k].kind == ROW_WRITE)
                cfg_write(dir_table[k].index, dir_table[k].data);
            else
                send_item(dir_table[k].item, dir_table[k].known, dir_table[k].want);
        end

        // random traffic: each idling mode under fresh register settings
        for (int mode_sel = 0; mode_sel < 4; mode_sel++) begin
            for (int set = 0; set < SETS_PER_MODE; set++) begin
                cfg_write(lif_pkg::REG_LEAK_RATE,         draw_reg(16'h0200));
                cfg_write(lif_pkg::REG_FIRE_THRESHOLD,    draw_reg(16'h3000));
                cfg_write(lif_pkg::REG_REFRACTORY_PERIOD, draw_reg(16'h3000));
                cfg_write(lif_pkg::REG_TIME_STEP,         draw_reg(16'h1000));
                send_idle_pct  = SEND_IDLE_PCT[mode_sel];
                recv_stall_pct = RECV_STALL_PCT[mode_sel];
                // long result hold-off while the sender keeps pushing
                if (mode_sel == 0 && set == 0)
                    hold_go = 1'b1;
                for (int n = 0; n < ITEMS_PER_SET; n++) begin
                    it = draw_item();
                    send_item(it, 1'b0, '0);
                end
            end
        end

        // drain and let stray beats show up
        in_ch.valid = 1'b0;
        while (spike_q.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d input beats (%0d ticks), %0d spikes, %0d register writes",
                 item_cnt, tick_cnt, spike_cnt, write_cnt);
        $display("input stalled %0d cycles by back-pressure, %0d mismatches",
                 backpress_cnt, mismatch_cnt);
        if (mismatch_cnt == 0 && spike_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: leaky_integrate_fire_neuron.f
hw/rtl/lif_pkg.sv
hw/rtl/lif_if.sv
hw/rtl/lif_cfg_regs.sv
hw/rtl/lif_core.sv
hw/rtl/leaky_integrate_fire_neuron.sv
hw/rtl/lif_checker.sv
tb/sv/tb_leaky_integrate_fire_neuron.sv
